FILE: hw/rtl/srt_pkg.sv
// shared types and constants for the signature rule tokenizer
// no dependencies; used by every module of the block and by its checker
package srt_pkg;

  localparam int KEYWORD_BYTES = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KW1_TEXT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KW1_LEN  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KW2_TEXT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KW2_LEN  = 2'd3;

  // reset values: "include" and "sig"
  localparam logic [CFG_DATA_W-1:0] KW1_TEXT_RESET = 64'd28539428140183145;
  localparam logic [3:0]            KW1_LEN_RESET  = 4'd7;
  localparam logic [CFG_DATA_W-1:0] KW2_TEXT_RESET = 64'd6777203;
  localparam logic [3:0]            KW2_LEN_RESET  = 4'd3;

  // token kinds
  localparam logic [3:0] KIND_TEXT   = 4'd0;
  localparam logic [3:0] KIND_END    = 4'd1;
  localparam logic [3:0] KIND_KW1    = 4'd2;
  localparam logic [3:0] KIND_KW2    = 4'd3;
  localparam logic [3:0] KIND_IDENT  = 4'd4;
  localparam logic [3:0] KIND_STRING = 4'd5;
  localparam logic [3:0] KIND_COLON  = 4'd6;
  localparam logic [3:0] KIND_LBRACE = 4'd7;
  localparam logic [3:0] KIND_RBRACE = 4'd8;
  localparam logic [3:0] KIND_LPAREN = 4'd9;
  localparam logic [3:0] KIND_RPAREN = 4'd10;
  localparam logic [3:0] KIND_EQUALS = 4'd11;
  localparam logic [3:0] KIND_DOT    = 4'd12;
  localparam logic [3:0] KIND_ERROR  = 4'd13;

  // characters
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
    logic       valid;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;   // res[0] goes out first
    logic [1:0]                count;
  } batch_t;

endpackage

FILE: hw/rtl/srt_scan.sv
// scanner state and per-byte token decode for the signature rule tokenizer
// depends on srt_pkg; produces the batch of up to three results for one item
module srt_scan #(
  parameter int KEYWORD_BYTES = srt_pkg::KEYWORD_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [7:0]                   data_byte,
  input  logic                         byte_present,
  input  logic                         end_of_text,
  input  logic [8*KEYWORD_BYTES-1:0]   kw1_text,
  input  logic [3:0]                   kw1_len,
  input  logic [8*KEYWORD_BYTES-1:0]   kw2_text,
  input  logic [3:0]                   kw2_len,
  output srt_pkg::batch_t              batch
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_STR  = 2'd2;
  localparam logic [1:0] MODE_DROP = 2'd3;

  logic [1:0] scan_mode, scan_mode_next;
  logic [3:0] word_length, word_length_next;
  logic [1:0] match_flags, match_flags_next;

  function automatic logic kw_ok(input logic [8*KEYWORD_BYTES-1:0] text,
                                 input logic [3:0] idx, input logic [7:0] c);
    logic r;
    r = 1'b0;
    for (int i = 0; i < KEYWORD_BYTES; i++) begin
      if (idx == 4'(i)) r = (text[8*i +: 8] == c);
    end
    return r;
  endfunction

  function automatic logic [3:0] close_kind_of(input logic [1:0] flags,
                                               input logic [3:0] wlen);
    logic [3:0] k;
    k = srt_pkg::KIND_IDENT;
    if (flags[0] && kw1_len <= 4'(KEYWORD_BYTES) && wlen == kw1_len) begin
      k = srt_pkg::KIND_KW1;
    end else if (flags[1] && kw2_len <= 4'(KEYWORD_BYTES) && wlen == kw2_len) begin
      k = srt_pkg::KIND_KW2;
    end
    return k;
  endfunction

  logic is_space, is_alpha, is_word;
  assign is_space = (data_byte == 8'h20) || (data_byte >= 8'h09 && data_byte <= 8'h0D);
  assign is_alpha = (data_byte >= 8'h41 && data_byte <= 8'h5A) ||
                    (data_byte >= 8'h61 && data_byte <= 8'h7A);
  assign is_word  = is_alpha || (data_byte >= 8'h30 && data_byte <= 8'h39) ||
                    (data_byte == srt_pkg::CH_UNDER);

  always_comb begin
    logic [1:0] mode_v;
    logic [3:0] wlen_v;
    logic [1:0] flags_v;
    logic [1:0] n;
    logic       do_start;
    logic       do_word;
    logic       do_close;
    logic [3:0] close_kind;
    srt_pkg::result_t [srt_pkg::MAX_RESULTS-1:0] res;

    mode_v   = scan_mode;
    wlen_v   = word_length;
    flags_v  = match_flags;
    n        = 2'd0;
    do_start = 1'b0;
    do_word  = 1'b0;
    do_close = 1'b0;
    res      = '0;

    // kind that closes the word held in the state registers
    close_kind = srt_pkg::KIND_IDENT;
    if (match_flags[0] && kw1_len <= 4'(KEYWORD_BYTES) && word_length == kw1_len) begin
      close_kind = srt_pkg::KIND_KW1;
    end else if (match_flags[1] && kw2_len <= 4'(KEYWORD_BYTES) &&
                 word_length == kw2_len) begin
      close_kind = srt_pkg::KIND_KW2;
    end

    if (byte_present) begin
      unique case (scan_mode)
        MODE_WORD: begin
          if (is_word) begin
            do_word = 1'b1;
          end else begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_STR: begin
          if (data_byte == srt_pkg::CH_QUOTE) begin
            res[n] = '{srt_pkg::KIND_STRING, 8'd0, 1'b0};
            n = n + 2'd1;
            mode_v = MODE_IDLE;
          end else begin
            res[n] = '{srt_pkg::KIND_TEXT, data_byte, 1'b1};
            n = n + 2'd1;
          end
        end
        MODE_DROP: begin
        end
        default: begin
          do_start = 1'b1;
        end
      endcase
    end

    // byte that ends a word closes it first
    if (do_close) begin
      res[n] = '{close_kind, 8'd0, 1'b0};
      n = n + 2'd1;
      mode_v  = MODE_IDLE;
      wlen_v  = 4'd0;
      flags_v = 2'b11;
    end

    if (do_start && !is_space) begin
      if (is_alpha || data_byte == srt_pkg::CH_UNDER) begin
        mode_v  = MODE_WORD;
        wlen_v  = 4'd0;
        flags_v = 2'b11;
        do_word = 1'b1;
      end else begin
        unique case (data_byte)
          srt_pkg::CH_COLON:  begin res[n] = '{srt_pkg::KIND_COLON, 8'd0, 1'b0};  n = n + 2'd1; end
          srt_pkg::CH_LBRACE: begin res[n] = '{srt_pkg::KIND_LBRACE, 8'd0, 1'b0}; n = n + 2'd1; end
          srt_pkg::CH_RBRACE: begin res[n] = '{srt_pkg::KIND_RBRACE, 8'd0, 1'b0}; n = n + 2'd1; end
          srt_pkg::CH_LPAREN: begin res[n] = '{srt_pkg::KIND_LPAREN, 8'd0, 1'b0}; n = n + 2'd1; end
          srt_pkg::CH_RPAREN: begin res[n] = '{srt_pkg::KIND_RPAREN, 8'd0, 1'b0}; n = n + 2'd1; end
          srt_pkg::CH_EQUALS: begin res[n] = '{srt_pkg::KIND_EQUALS, 8'd0, 1'b0}; n = n + 2'd1; end
          srt_pkg::CH_DOT:    begin res[n] = '{srt_pkg::KIND_DOT, 8'd0, 1'b0};    n = n + 2'd1; end
          srt_pkg::CH_QUOTE:  begin mode_v = MODE_STR; end
          default: begin
            res[n] = '{srt_pkg::KIND_ERROR, data_byte, 1'b1};
            n = n + 2'd1;
            mode_v = MODE_DROP;
          end
        endcase
      end
    end

    if (do_word) begin
      if (!kw_ok(kw1_text, wlen_v, data_byte)) flags_v[0] = 1'b0;
      if (!kw_ok(kw2_text, wlen_v, data_byte)) flags_v[1] = 1'b0;
      if (wlen_v != 4'd15) wlen_v = wlen_v + 4'd1;
      res[n] = '{srt_pkg::KIND_TEXT, data_byte, 1'b1};
      n = n + 2'd1;
    end

    if (end_of_text) begin
      if (mode_v == MODE_WORD) begin
        // a word can only still be open here if no byte closed it
        res[n] = '{close_kind_of(flags_v, wlen_v), 8'd0, 1'b0};
        n = n + 2'd1;
      end else if (mode_v == MODE_STR) begin
        res[n] = '{srt_pkg::KIND_STRING, 8'd0, 1'b0};
        n = n + 2'd1;
      end
      res[n] = '{srt_pkg::KIND_END, 8'd0, 1'b0};
      n = n + 2'd1;
      mode_v  = MODE_IDLE;
      wlen_v  = 4'd0;
      flags_v = 2'b11;
    end

    batch.res        = res;
    batch.count      = n;
    scan_mode_next   = mode_v;
    word_length_next = wlen_v;
    match_flags_next = flags_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= MODE_IDLE;
      word_length <= 4'd0;
      match_flags <= 2'b11;
    end else if (step) begin
      scan_mode   <= scan_mode_next;
      word_length <= word_length_next;
      match_flags <= match_flags_next;
    end
  end

endmodule

FILE: hw/rtl/srt_batch.sv
// result register for the signature rule tokenizer: holds one item's batch
// depends on srt_pkg; shifts results out one per transfer
module srt_batch (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  srt_pkg::batch_t  batch_in,
  input  logic             out_ready,
  output logic             out_valid,
  output srt_pkg::result_t out_res,
  output logic             out_last,
  output logic             free
);

  srt_pkg::result_t [srt_pkg::MAX_RESULTS-1:0] slots;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign out_res   = slots[0];
  assign out_last  = (count == 2'd1);
  assign pop       = out_valid && out_ready;
  assign free      = (count == 2'd0) || (count == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= batch_in.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= batch_in.res;
    end else if (pop) begin
      for (int i = 0; i < srt_pkg::MAX_RESULTS - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

endmodule

FILE: hw/rtl/signature_rule_tokenizer_unit.sv
// top level of the signature rule tokenizer: input register, keyword registers,
// scanner and result register; depends on srt_pkg, srt_scan and srt_batch
//
// Streams rule text one byte per input transfer and emits tokens: word and
// string bytes pass through as text results, each word or string is closed by
// a KW1, KW2, IDENT or STRING token, punctuation gives its own token, a bad
// start byte gives an error token and the rest of the text is dropped, and the
// end of the text gives END. An accepted item is held in the input register,
// is decoded combinationally into up to three results held in the result
// register, and those leave one per output transfer. The block takes one item
// per cycle as long as each item yields at most one result and the output is
// not stalled; an item yielding more results (at most three) holds up the next
// one until all but its last result have left, which is what sets the rate.
// Items yielding no result (whitespace, dropped bytes) never wait for the output.
// The keyword registers may be written only while the block is idle.
module signature_rule_tokenizer_unit #(
  parameter int KEYWORD_BYTES = srt_pkg::KEYWORD_BYTES
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] data_byte
  input  logic                               s_tuser,   // [0] byte_present
  input  logic                               s_tlast,   // end_of_text
  // token stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [15:0]                        m_tdata,   // [7:0] text_byte, [8] text_valid
  output logic [3:0]                         m_tuser,   // [3:0] token_kind
  output logic                               m_tlast,   // last_of_run
  // keyword register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [srt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int KW_W = 8 * KEYWORD_BYTES;

  // keyword registers, only the bytes a word can ever be compared with
  logic [KW_W-1:0] kw1_text, kw2_text;
  logic [3:0]      kw1_len, kw2_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kw1_text <= srt_pkg::KW1_TEXT_RESET[KW_W-1:0];
      kw1_len  <= srt_pkg::KW1_LEN_RESET;
      kw2_text <= srt_pkg::KW2_TEXT_RESET[KW_W-1:0];
      kw2_len  <= srt_pkg::KW2_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srt_pkg::REG_KW1_TEXT: kw1_text <= cfg_data[KW_W-1:0];
        srt_pkg::REG_KW1_LEN:  kw1_len  <= cfg_data[3:0];
        srt_pkg::REG_KW2_TEXT: kw2_text <= cfg_data[KW_W-1:0];
        srt_pkg::REG_KW2_LEN:  kw2_len  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_present;
  logic       in_end;
  logic       advance;
  logic       batch_free;
  logic       load;
  srt_pkg::batch_t  batch;
  srt_pkg::result_t head;
  logic             head_last;

  // an item moves on when the result register can take its batch, or at once
  // when it yields nothing
  assign advance  = in_full && (batch_free || batch.count == 2'd0);
  assign load     = advance && batch.count != 2'd0;
  assign s_tready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte    <= s_tdata;
      in_present <= s_tuser;
      in_end     <= s_tlast;
    end
  end

  srt_scan #(
    .KEYWORD_BYTES(KEYWORD_BYTES)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .data_byte    (in_byte),
    .byte_present (in_present),
    .end_of_text  (in_end),
    .kw1_text     (kw1_text),
    .kw1_len      (kw1_len),
    .kw2_text     (kw2_text),
    .kw2_len      (kw2_len),
    .batch        (batch)
  );

  srt_batch u_batch (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .batch_in  (batch),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (head),
    .out_last  (head_last),
    .free      (batch_free)
  );

  assign m_tdata = {7'd0, head.valid, head.data};
  assign m_tuser = head.kind;
  assign m_tlast = head_last;

endmodule

FILE: hw/rtl/srt_checker.sv
// port-level checks for the signature rule tokenizer, bound to its top level
// depends on srt_pkg and signature_rule_tokenizer_unit
module srt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled token holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
      $stable(m_tlast))
    else $error("token changed while stalled");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("token valid after reset");

  // text_valid only on text and error tokens
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[8] == (m_tuser == srt_pkg::KIND_TEXT ||
                                m_tuser == srt_pkg::KIND_ERROR))
    else $error("text_valid does not match token kind");

  // tokens without text carry a zero byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
    else $error("text byte set on a token without text");

  // END is always the last token of its item
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == srt_pkg::KIND_END |-> m_tlast)
    else $error("END not last of its run");

endmodule

bind signature_rule_tokenizer_unit srt_checker u_srt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: dv/signature_rule_tokenizer_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for signature_rule_tokenizer_unit: token predictor and scoreboard,
// directed and random rule text, keyword register writes; depends on srt_pkg and the rtl
module signature_rule_tokenizer_unit_tb;
  import srt_pkg::*;

  // scanner state as the predictor tracks it
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_WORD,
    SCAN_STRING,
    SCAN_DROP
  } scan_t;

  // one expected token transfer
  typedef struct {
    logic [3:0] kind;
    logic [7:0] txt;
    logic       txt_ok;
    logic       last;
  } token_t;

  // one input transfer of rule text
  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eot;
  } text_item_t;

  // token predictor and in-order checker
  class token_scoreboard;
    logic [63:0] kw_text [2];
    logic [3:0]  kw_len [2];
    scan_t       mode;
    logic [3:0]  word_len;
    logic [1:0]  kw_live;    // bit 0: still matches keyword 1, bit 1: keyword 2
    token_t      expected_tokens [$];
    int          mismatches;

    function new();
      kw_text[0]  = KW1_TEXT_RESET;
      kw_len[0]   = KW1_LEN_RESET;
      kw_text[1]  = KW2_TEXT_RESET;
      kw_len[1]   = KW2_LEN_RESET;
      mode        = SCAN_IDLE;
      word_len    = 4'd0;
      kw_live     = 2'b11;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_KW1_TEXT: kw_text[0] = val;
        REG_KW1_LEN:  kw_len[0]  = val[3:0];
        REG_KW2_TEXT: kw_text[1] = val;
        REG_KW2_LEN:  kw_len[1]  = val[3:0];
        default: ;
      endcase
    endfunction

    function void push(logic [3:0] kind, logic [7:0] txt, logic txt_ok);
      token_t t;
      t.kind   = kind;
      t.txt    = txt;
      t.txt_ok = txt_ok;
      t.last   = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function bit kw_byte_matches(logic [63:0] text, logic [3:0] idx, logic [7:0] c);
      if (idx >= KEYWORD_BYTES) return 1'b0;
      return text[8*idx +: 8] == c;
    endfunction

    function void word_byte(logic [7:0] c);
      if (!kw_byte_matches(kw_text[0], word_len, c)) kw_live[0] = 1'b0;
      if (!kw_byte_matches(kw_text[1], word_len, c)) kw_live[1] = 1'b0;
      if (word_len != 4'd15) word_len = word_len + 4'd1;
      push(KIND_TEXT, c, 1'b1);
    endfunction

    // keyword 1 wins over keyword 2; lengths beyond the keyword store never match
    function void close_word();
      logic [3:0] kind;
      kind = KIND_IDENT;
      if (kw_live[0] && kw_len[0] <= KEYWORD_BYTES && word_len == kw_len[0])
        kind = KIND_KW1;
      else if (kw_live[1] && kw_len[1] <= KEYWORD_BYTES && word_len == kw_len[1])
        kind = KIND_KW2;
      push(kind, 8'd0, 1'b0);
      mode     = SCAN_IDLE;
      word_len = 4'd0;
      kw_live  = 2'b11;
    endfunction

    function void start_byte(logic [7:0] c);
      if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return;
      if (is_alpha(c) || c == CH_UNDER) begin
        mode     = SCAN_WORD;
        word_len = 4'd0;
        kw_live  = 2'b11;
        word_byte(c);
        return;
      end
      case (c)
        CH_COLON:  push(KIND_COLON, 8'd0, 1'b0);
        CH_LBRACE: push(KIND_LBRACE, 8'd0, 1'b0);
        CH_RBRACE: push(KIND_RBRACE, 8'd0, 1'b0);
        CH_LPAREN: push(KIND_LPAREN, 8'd0, 1'b0);
        CH_RPAREN: push(KIND_RPAREN, 8'd0, 1'b0);
        CH_EQUALS: push(KIND_EQUALS, 8'd0, 1'b0);
        CH_DOT:    push(KIND_DOT, 8'd0, 1'b0);
        CH_QUOTE:  mode = SCAN_STRING;   // opening quote gives no token
        default: begin
          push(KIND_ERROR, c, 1'b1);
          mode = SCAN_DROP;
        end
      endcase
    endfunction

    // predict the tokens one accepted input transfer causes
    function void note_item(logic [7:0] c, logic present, logic eot);
      int old_size;
      old_size = expected_tokens.size();
      if (present) begin
        case (mode)
          SCAN_WORD: begin
            if (is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER) begin
              word_byte(c);
            end else begin
              // the ending byte closes the word, then counts as a start byte
              close_word();
              start_byte(c);
            end
          end
          SCAN_STRING: begin
            if (c == CH_QUOTE) begin
              push(KIND_STRING, 8'd0, 1'b0);
              mode = SCAN_IDLE;
            end else begin
              push(KIND_TEXT, c, 1'b1);
            end
          end
          SCAN_DROP: ;
          default: start_byte(c);
        endcase
      end
      if (eot) begin
        // open word or string closes first, END follows even when dropping
        if (mode == SCAN_WORD) close_word();
        else if (mode == SCAN_STRING) push(KIND_STRING, 8'd0, 1'b0);
        push(KIND_END, 8'd0, 1'b0);
        mode     = SCAN_IDLE;
        word_len = 4'd0;
        kw_live  = 2'b11;
      end
      if (expected_tokens.size() > old_size)
        expected_tokens[expected_tokens.size()-1].last = 1'b1;
    endfunction

    function void check_token(logic [3:0] kind, logic [15:0] data, logic last);
      token_t want;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d data %h last %0b", kind, data, last);
        return;
      end
      want = expected_tokens.pop_front();
      if (kind !== want.kind || data !== {7'd0, want.txt_ok, want.txt} || last !== want.last)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display({"token mismatch: expected kind %0d data %h last %0b, ",
                    "got kind %0d data %h last %0b"},
                   want.kind, {7'd0, want.txt_ok, want.txt}, want.last, kind, data, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;      // [7:0] data_byte
  logic        s_tuser = 1'b0;      // [0] byte_present
  logic        s_tlast = 1'b0;      // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;             // [7:0] text_byte, [8] text_valid
  logic [3:0]  m_tuser;             // [3:0] token_kind
  logic        m_tlast;             // last_of_run
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_KW1_TEXT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  token_scoreboard sb;
  text_item_t      text_items [$];
  int              send_pct  = 0;   // chance in percent that the sender idles a cycle
  int              stall_pct = 0;   // chance in percent that the receiver stalls a cycle

  signature_rule_tokenizer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: ready changes on the falling edge, tokens are checked on the rising edge
  always @(negedge clk) m_tready <= ($urandom_range(99, 0) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_token(m_tuser, m_tdata, m_tlast);
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // one input transfer; enters and leaves on a falling edge, leaves tvalid high
  task automatic send_item(logic [7:0] d, logic p, logic e);
    while ($urandom_range(99, 0) < send_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= p;
    s_tlast  <= e;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(d, p, e);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic write_keywords(logic [63:0] t1, logic [3:0] l1,
                                logic [63:0] t2, logic [3:0] l2);
    write_reg(REG_KW1_TEXT, t1);
    write_reg(REG_KW1_LEN, {60'd0, l1});
    write_reg(REG_KW2_TEXT, t2);
    write_reg(REG_KW2_LEN, {60'd0, l2});
    cfg_valid <= 1'b0;
  endtask

  // stop sending, wait for every expected token, then let the pipeline empty
  // of items that gave no token, with margin
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [63:0] pack_kw(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    text_item_t it;
    it.data    = b;
    it.present = 1'b1;
    it.eot     = 1'b0;
    text_items.push_back(it);
  endfunction

  function automatic logic [7:0] word_char(bit first);
    int r;
    r = $urandom_range(first ? 52 : 62, 0);
    if (r < 26) return 8'(8'h41 + r);
    if (r < 52) return 8'(8'h61 + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'(8'h30 + r - 53);
  endfunction

  function automatic void add_punct();
    case ($urandom_range(6, 0))
      0: push_byte(CH_COLON);
      1: push_byte(CH_LBRACE);
      2: push_byte(CH_RBRACE);
      3: push_byte(CH_LPAREN);
      4: push_byte(CH_RPAREN);
      5: push_byte(CH_EQUALS);
      default: push_byte(CH_DOT);
    endcase
  endfunction

  function automatic void add_space();
    int r;
    r = $urandom_range(5, 0);
    push_byte(r == 5 ? 8'h20 : 8'(8'h09 + r));
  endfunction

  // keyword words, near misses and plain identifiers, some past the length counter
  function automatic void add_word();
    int pick, n, k;
    logic [63:0] kt;
    pick = $urandom_range(9, 0);
    if (pick < 4) begin
      k  = pick % 2;
      kt = sb.kw_text[k];
      n  = (sb.kw_len[k] > 8) ? 8 : sb.kw_len[k];
      if (pick >= 2 && n > 1 && $urandom_range(1, 0)) n--;
      for (int i = 0; i < n; i++) push_byte(kt[8*i +: 8]);
      if (n == 0) push_byte(word_char(1'b1));
      else if (pick >= 2) push_byte(word_char(1'b0));
    end else begin
      n = (pick == 9) ? $urandom_range(18, 14) : $urandom_range(5, 1);
      push_byte(word_char(1'b1));
      for (int i = 1; i < n; i++) push_byte(word_char(1'b0));
    end
  endfunction

  function automatic void add_token();
    int r, n;
    logic [7:0] b;
    text_item_t it;
    r = $urandom_range(99, 0);
    if (r < 40) begin
      add_word();
      r = $urandom_range(9, 0);
      if (r < 5) add_space();
      else if (r < 8) add_punct();
    end else if (r < 58) begin
      add_punct();
    end else if (r < 74) begin
      // string body takes any byte but the quote; a few stay open to the end
      push_byte(CH_QUOTE);
      n = $urandom_range(5, 0);
      repeat (n) begin
        b = 8'($urandom_range(255, 0));
        push_byte(b == CH_QUOTE ? 8'h27 : b);
      end
      if ($urandom_range(9, 0) != 0) push_byte(CH_QUOTE);
    end else if (r < 90) begin
      add_space();
    end else if (r < 96) begin
      push_byte(8'($urandom_range(255, 0)));
    end else begin
      it.data    = 8'($urandom_range(255, 0));
      it.present = 1'b0;
      it.eot     = 1'b0;
      text_items.push_back(it);
    end
  endfunction

  // one rule text: a few tokens, ended on the last byte or by an end-only transfer
  function automatic void build_text();
    text_item_t it;
    text_items.delete();
    repeat ($urandom_range(6, 2)) add_token();
    if ($urandom_range(1, 0)) begin
      text_items[text_items.size()-1].eot = 1'b1;
    end else begin
      it.data    = 8'($urandom_range(255, 0));
      it.present = 1'b0;
      it.eot     = 1'b1;
      text_items.push_back(it);
    end
  endfunction

  task automatic run_random(int idle_s, int stall_r, int n_items);
    int sent;
    send_pct  = idle_s;
    stall_pct = stall_r;
    sent = 0;
    while (sent < n_items) begin
      build_text();
      foreach (text_items[i]) begin
        send_item(text_items[i].data, text_items[i].present, text_items[i].eot);
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed text with reset keywords include / sig
    send_item("s", 1'b1, 1'b0);
    send_item("i", 1'b1, 1'b0);
    send_item("g", 1'b1, 1'b0);
    send_item(CH_LPAREN, 1'b1, 1'b0);   // closes KW2, then its own token
    send_item(CH_UNDER, 1'b1, 1'b0);
    send_item("x", 1'b1, 1'b0);
    send_item("9", 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);       // high byte ends word and is an error
    send_item("a", 1'b1, 1'b0);         // dropped
    send_item(8'h00, 1'b0, 1'b1);       // end-only transfer while dropping
    send_item(CH_QUOTE, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);       // high byte passes inside a string
    send_item(CH_QUOTE, 1'b1, 1'b0);
    send_item(CH_LBRACE, 1'b1, 1'b0);
    send_item(CH_RBRACE, 1'b1, 1'b0);
    send_item(CH_RPAREN, 1'b1, 1'b0);
    send_item(CH_EQUALS, 1'b1, 1'b0);
    send_item(CH_DOT, 1'b1, 1'b0);
    send_item(CH_COLON, 1'b1, 1'b0);
    send_item(8'h0B, 1'b1, 1'b0);
    send_item(8'h0D, 1'b1, 1'b0);
    send_item(CH_QUOTE, 1'b1, 1'b0);
    send_item("q", 1'b1, 1'b1);         // unterminated string closed at end of text
    send_item(8'hA5, 1'b0, 1'b0);       // no byte, no end: nothing happens
    send_item("Z", 1'b1, 1'b1);         // text, IDENT and END from one transfer
    run_random(0, 0, 64);

    // single-byte and full-width keywords
    write_keywords(pack_kw("_"), 4'd1, pack_kw("Zz0_9abc"), 4'd8);
    run_random(86, 0, 64);

    // unmatchable first keyword with maximum length value, one-letter second
    write_keywords(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, pack_kw("x"), 4'd1);
    run_random(0, 86, 64);

    // identical keywords: the first one takes priority
    write_keywords(pack_kw("sig"), 4'd3, pack_kw("sig"), 4'd3);
    run_random(20, 20, 64);

    // zero length and one byte past the keyword store
    write_keywords(64'd0, 4'd0, pack_kw("abcdefgh"), 4'd9);
    run_random(0, 0, 64);

    if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
